// ----- design/rlim_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rlim_pkg;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int MS_PER_SECOND   = 1000;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int TIME_W          = 32;
    localparam int ID_W            = 32;
    // window in ms fits 26 bits: 65535 * 1000 < 2**26
    localparam int WMS_W           = 26;
    localparam int DIV_CNT_W       = 5;
    localparam int ENTRY_W         = 1 + ID_W + TIME_W;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVATION_LIMIT = 2'd1;

    localparam logic ACT_ACTIVATE = 1'b0;
    localparam logic ACT_CLEAN    = 1'b1;

    typedef struct packed {
        logic              action;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now_ms;
        logic              remove_on_limit;
        logic              enabled;
        logic [WMS_W-1:0]  inc;
        logic [WMS_W-1:0]  window_ms;
    } t_job;
endpackage
`default_nettype wire

// ----- design/rlim_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rlim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- design/rlim_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rlim_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic                           i_action,
    input  wire logic [rlim_pkg::ID_W-1:0]      i_id,
    input  wire logic [rlim_pkg::TIME_W-1:0]    i_now_ms,
    input  wire logic                           i_remove_on_limit,
    input  wire logic [rlim_pkg::CFG_W-1:0]     i_window_seconds,
    input  wire logic [rlim_pkg::CFG_W-1:0]     i_activation_limit,
    input  wire logic                           i_q_full,
    output logic                                o_push,
    output rlim_pkg::t_job                      o_job,
    output logic                                o_busy
);
    localparam int WW = rlim_pkg::WMS_W;
    localparam logic [rlim_pkg::DIV_CNT_W-1:0] CNT_DONE = rlim_pkg::DIV_CNT_W'(WW);

    logic                               r_valid;
    logic [rlim_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [WW-1:0]                      r_quo;
    logic [rlim_pkg::CFG_W:0]           r_rem;
    logic [rlim_pkg::CFG_W-1:0]         r_lim;
    rlim_pkg::t_job                     r_job;

    logic [rlim_pkg::CFG_W:0] rem_sh;
    logic                     ge;
    logic                     en;
    logic [WW-1:0]            win;

    assign en     = (i_window_seconds != '0) && (i_activation_limit != '0);
    assign win    = WW'(i_window_seconds) * WW'(rlim_pkg::MS_PER_SECOND);
    assign rem_sh = {r_rem[rlim_pkg::CFG_W-1:0], r_quo[WW-1]};
    assign ge     = rem_sh >= {1'b0, r_lim};
    assign o_push = r_valid && (r_cnt == CNT_DONE) && !i_q_full;
    assign o_busy = r_valid;

    always_comb begin
        o_job     = r_job;
        o_job.inc = r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_accept) begin
                r_valid <= 1'b1;
                r_cnt   <= (i_action == rlim_pkg::ACT_CLEAN || !en) ? CNT_DONE : '0;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end else if (r_valid && r_cnt != CNT_DONE) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_quo                 <= win;
            r_rem                 <= '0;
            r_lim                 <= i_activation_limit;
            r_job.action          <= i_action;
            r_job.id              <= i_id;
            r_job.now_ms          <= i_now_ms;
            r_job.remove_on_limit <= i_remove_on_limit;
            r_job.enabled         <= en;
            r_job.inc             <= '0;
            r_job.window_ms       <= win;
        end else if (r_valid && r_cnt != CNT_DONE) begin
            r_quo <= {r_quo[WW-2:0], ge};
            r_rem <= ge ? (rem_sh - {1'b0, r_lim}) : rem_sh;
        end
    end
endmodule
`default_nettype wire

// ----- design/rlim_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rlim_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire rlim_pkg::t_job i_job,
    input  wire logic           i_pop,
    output rlim_pkg::t_job      o_job,
    output logic                o_full,
    output logic                o_empty
);
    rlim_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule
`default_nettype wire

// ----- design/rlim_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rlim_back #(
    parameter int TABLE_DEPTH = rlim_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rlim_pkg::t_job i_job,
    input  wire logic           i_q_empty,
    output logic                o_pop,
    output logic                o_clearing,
    output logic                o_done,
    output logic                o_limited,
    output logic                o_table_full
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = rlim_pkg::ENTRY_W;
    localparam int TW = rlim_pkg::TIME_W;
    localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]     r_state;
    logic [AW-1:0]  r_addr;
    logic           r_issue;
    logic           r_chk_v;
    logic [AW-1:0]  r_chk_addr;
    rlim_pkg::t_job r_job;
    logic           r_hit;
    logic [AW-1:0]  r_hit_addr;
    logic [TW-1:0]  r_hit_dl;
    logic           r_free;
    logic [AW-1:0]  r_free_addr;

    logic           we;
    logic [AW-1:0]  waddr;
    logic [EW-1:0]  wdata;
    logic           re;
    logic [EW-1:0]  rdata;
    logic           rd_valid;
    logic [TW-1:0]  rd_key;
    logic [TW-1:0]  rd_dl;
    logic [TW-1:0]  inc;
    logic [TW-1:0]  win;
    logic [TW-1:0]  now_inc;
    logic [TW-1:0]  next_dl;
    logic           over;

    assign {rd_valid, rd_key, rd_dl} = rdata;
    assign inc     = TW'(r_job.inc);
    assign win     = TW'(r_job.window_ms);
    assign now_inc = r_job.now_ms + inc;
    assign next_dl = r_hit_dl + inc;
    assign over    = next_dl > (r_job.now_ms + win);

    assign o_pop      = (r_state == S_IDLE) && !i_q_empty;
    assign o_clearing = r_state == S_CLR;
    assign re         = (r_state == S_SCAN) && r_issue;

    rlim_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        we    = 1'b0;
        waddr = r_chk_addr;
        wdata = '0;
        case (r_state)
            S_CLR: begin
                we    = 1'b1;
                waddr = r_addr;
            end
            S_SCAN: begin
                // clean: drop expired entries as they stream past
                we = r_chk_v && (r_job.action == rlim_pkg::ACT_CLEAN) && rd_valid
                     && (rd_dl < r_job.now_ms);
            end
            S_FIN: begin
                if (r_job.action == rlim_pkg::ACT_ACTIVATE && r_job.enabled) begin
                    if (!r_hit) begin
                        we    = r_free;
                        waddr = r_free_addr;
                        wdata = {1'b1, r_job.id, now_inc};
                    end else begin
                        we    = 1'b1;
                        waddr = r_hit_addr;
                        if (r_hit_dl < r_job.now_ms) begin
                            wdata = {1'b1, r_job.id, now_inc};
                        end else if (over && r_job.remove_on_limit) begin
                            wdata = '0;
                        end else begin
                            wdata = {1'b1, r_job.id, next_dl};
                        end
                    end
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr  <= '0;
            r_issue <= 1'b0;
            r_chk_v <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            o_done  <= 1'b0;
            r_chk_v <= re;
            case (r_state)
                S_CLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_addr  <= '0;
                        r_issue <= 1'b1;
                        if (i_job.action == rlim_pkg::ACT_ACTIVATE && !i_job.enabled) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_issue) begin
                        r_addr <= r_addr + 1'b1;
                        if (r_addr == LAST) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (r_chk_v && r_chk_addr == LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    o_done  <= 1'b1;
                    r_issue <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_addr <= r_addr;
        if (o_pop) begin
            r_job  <= i_job;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (r_state == S_SCAN && r_chk_v) begin
            if (rd_valid) begin
                if (!r_hit && rd_key == r_job.id) begin
                    r_hit      <= 1'b1;
                    r_hit_addr <= r_chk_addr;
                    r_hit_dl   <= rd_dl;
                end
            end else if (!r_free) begin
                r_free      <= 1'b1;
                r_free_addr <= r_chk_addr;
            end
        end
        if (r_state == S_FIN) begin
            o_limited    <= 1'b0;
            o_table_full <= 1'b0;
            if (r_job.action == rlim_pkg::ACT_ACTIVATE && r_job.enabled) begin
                o_table_full <= !r_hit && !r_free;
                o_limited    <= r_hit && !(r_hit_dl < r_job.now_ms) && over;
            end
        end
    end
endmodule
`default_nettype wire

// ----- design/per_id_event_rate_limiter_top.sv -----
// Path: an activation passes the front's window multiply and 26-step divider for the
// increment, while a clean or disabled item skips the divider; the back strobes the result
// after scanning the whole table (a disabled activation skips the scan).
// Pacing: the back takes one item at a time and scans the whole table for each scanned item;
// a two-item queue lets the front prepare the next item meanwhile.
// Reset: the back clears the table with busy high; receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module per_id_event_rate_limiter_top #(
    parameter int TABLE_DEPTH = rlim_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // item channel
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_action,
    input  wire logic [rlim_pkg::ID_W-1:0]       i_id,
    input  wire logic [rlim_pkg::TIME_W-1:0]     i_now_ms,
    input  wire logic                            i_remove_on_limit,
    // result strobe
    output logic                                 o_done,
    output logic                                 o_limited,
    output logic                                 o_table_full,
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rlim_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rlim_pkg::CFG_W-1:0]      i_cfg_data
);
    logic [rlim_pkg::CFG_W-1:0] r_window_seconds;
    logic [rlim_pkg::CFG_W-1:0] r_activation_limit;

    logic           accept;
    logic           front_busy;
    logic           clearing;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    rlim_pkg::t_job f_job;
    rlim_pkg::t_job q_job;

    // writes are always taken; indexes beyond the list are ignored
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_seconds   <= '0;
            r_activation_limit <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rlim_pkg::REG_WINDOW_SECONDS:   r_window_seconds   <= i_cfg_data;
                rlim_pkg::REG_ACTIVATION_LIMIT: r_activation_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front holds one item at a time; no new item while the table is being cleared
    assign busy   = front_busy || clearing;
    assign accept = start && !busy;

    rlim_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_action           (i_action),
        .i_id               (i_id),
        .i_now_ms           (i_now_ms),
        .i_remove_on_limit  (i_remove_on_limit),
        .i_window_seconds   (r_window_seconds),
        .i_activation_limit (r_activation_limit),
        .i_q_full           (q_full),
        .o_push             (push),
        .o_job              (f_job),
        .o_busy             (front_busy)
    );

    rlim_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rlim_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (q_job),
        .i_q_empty    (q_empty),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_done       (o_done),
        .o_limited    (o_limited),
        .o_table_full (o_table_full)
    );
endmodule
`default_nettype wire
